### rtl/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, field widths and codes of the bilinear RGB image sampler.
// ----------------------------------------------------------------------------
package brs_pkg;

   localparam int COORD_WIDTH      = 17;
   localparam int CHAN_WIDTH       = 8;
   localparam int PIXEL_WIDTH      = 3 * CHAN_WIDTH;
   localparam int Q88_WIDTH        = 16;
   localparam int INDEX_WIDTH      = 16;
   localparam int SIZE_WIDTH       = 9;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int NUM_NEIGHBORS    = 4;
   localparam int NUM_CHANNELS     = 3;

   // Scaled coordinate: Q1.16 coordinate times a size minus one.
   localparam int XS_WIDTH         = COORD_WIDTH + SIZE_WIDTH;
   localparam int FRAC_WIDTH       = 16;
   // Row base and linear addresses stay below 511 * 511.
   localparam int ROW_WIDTH        = 2 * SIZE_WIDTH;
   // Bilinear weights are Q1.32 and reach 1.0 exactly.
   localparam int WEIGHT_WIDTH     = 2 * FRAC_WIDTH + 1;
   localparam int PROD_WIDTH       = WEIGHT_WIDTH + CHAN_WIDTH;
   localparam int ACC_WIDTH        = PROD_WIDTH + 1;
   localparam int ROUND_SHIFT      = 24;

   localparam logic [COORD_WIDTH-1:0] ONE_Q16    = COORD_WIDTH'(65536);
   localparam logic [ACC_WIDTH-1:0]   ROUND_HALF = ACC_WIDTH'(1) << (ROUND_SHIFT - 1);
   localparam int                     SIZE_RESET = 256;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_WIDTH'(1);

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;
   typedef logic [SIZE_WIDTH-1:0]  size_type;

   // A size of zero counts as one, a size above the store's limit as the limit.
   function automatic size_type clamp_size(input size_type raw, input int unsigned maxv);
      size_type result;
      if (raw == '0) begin
         result = SIZE_WIDTH'(1);
      end else if (32'(raw) > maxv) begin
         result = SIZE_WIDTH'(maxv);
      end else begin
         result = raw;
      end
      return result;
   endfunction

endpackage

### rtl/brs_ram.sv
// ----------------------------------------------------------------------------
// brs_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module brs_ram #(
   parameter int DATA_WIDTH = 24,
   parameter int DEPTH      = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [DATA_WIDTH-1:0]    rd_data_a,
   output logic [DATA_WIDTH-1:0]    rd_data_b
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_a_ff;
   logic [DATA_WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### rtl/bilinear_rgb_image_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_rgb_image_sampler
// The block takes one word per clock on req_, writes or samples alike, while
// rsp_ready is held high. A write word stores one RGB8 pixel at its linear
// index; indexes of MAX_WIDTH * MAX_HEIGHT and above are dropped. A sample
// word returns one rsp_ word with the bilinear blend of the four neighbors
// in Q8.8. Words are handled strictly in order, so a sample sees every write
// accepted before it. One word per cycle is sustained while rsp_ready is
// held high because the pixel store is kept as two identical copies with two
// read ports each, which return all four neighbors together. Pixels are
// undefined until written and the store has no clearing pass. The user must
// write size registers only while the block is idle, which is not enforced.
// A size of zero is used as one and a size above the maximum as the maximum.
// ----------------------------------------------------------------------------
module bilinear_rgb_image_sampler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input words
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic [brs_pkg::INDEX_WIDTH-1:0]      req_pixel_index,
   input  logic [brs_pkg::CHAN_WIDTH-1:0]       req_red_in,
   input  logic [brs_pkg::CHAN_WIDTH-1:0]       req_green_in,
   input  logic [brs_pkg::CHAN_WIDTH-1:0]       req_blue_in,
   input  logic [brs_pkg::COORD_WIDTH-1:0]      req_coord_u,
   input  logic [brs_pkg::COORD_WIDTH-1:0]      req_coord_v,
   input  logic                                 req_last_sample,
   // Result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [brs_pkg::Q88_WIDTH-1:0]        rsp_red_out,
   output logic [brs_pkg::Q88_WIDTH-1:0]        rsp_green_out,
   output logic [brs_pkg::Q88_WIDTH-1:0]        rsp_blue_out,
   output logic                                 rsp_last_out,
   // Configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [brs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [brs_pkg::SIZE_WIDTH-1:0]       csr_data
);

   import brs_pkg::*;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);

   localparam size_type WIDTH_RESET  =
      SIZE_WIDTH'((MAX_WIDTH < SIZE_RESET) ? MAX_WIDTH : SIZE_RESET);
   localparam size_type HEIGHT_RESET =
      SIZE_WIDTH'((MAX_HEIGHT < SIZE_RESET) ? MAX_HEIGHT : SIZE_RESET);

   // Size registers, kept already clamped.
   size_type width_ff;
   size_type height_ff;
   size_type width_m1;
   size_type height_m1;

   // Stage advance: a stage moves on when the next one is free or moving.
   logic adv1, adv2, adv3, adv4, adv5;

   // Stage 1: scaled coordinates and the write word.
   logic [COORD_WIDTH-1:0] u_sat;
   logic [COORD_WIDTH-1:0] v_sat;
   logic [COORD_WIDTH-1:0] v_flip;
   logic [XS_WIDTH-1:0]    s1_xs_in;
   logic [XS_WIDTH-1:0]    s1_ys_in;
   logic                   s1_wr_ok_in;

   logic                   s1_valid_ff;
   logic                   s1_func_ff;
   logic                   s1_last_ff;
   logic                   s1_wr_ok_ff;
   logic [ADDR_WIDTH-1:0]  s1_wr_addr_ff;
   pixel_type              s1_pixel_ff;
   logic [XS_WIDTH-1:0]    s1_xs_ff;
   logic [XS_WIDTH-1:0]    s1_ys_ff;

   // Stage 2: neighbor columns, row base and weights; RAM reads and writes.
   size_type                  ix0;
   size_type                  iy0;
   logic [FRAC_WIDTH-1:0]     fx;
   logic [FRAC_WIDTH-1:0]     fy;
   logic [SIZE_WIDTH:0]       ix0_inc;
   logic [SIZE_WIDTH:0]       iy0_inc;
   logic [COORD_WIDTH-1:0]    x_lo, x_hi, y_lo, y_hi;
   logic [2*COORD_WIDTH-1:0]  weight_full [NUM_NEIGHBORS];
   size_type                  s2_ix1_in;
   logic                      s2_step_y_in;
   logic [ROW_WIDTH-1:0]      s2_row0_in;
   logic [WEIGHT_WIDTH-1:0]   s2_weight_in [NUM_NEIGHBORS];

   logic                      s2_valid_ff;
   logic                      s2_func_ff;
   logic                      s2_last_ff;
   logic                      s2_wr_ok_ff;
   logic [ADDR_WIDTH-1:0]     s2_wr_addr_ff;
   pixel_type                 s2_pixel_ff;
   size_type                  s2_ix0_ff;
   size_type                  s2_ix1_ff;
   logic [ROW_WIDTH-1:0]      s2_row0_ff;
   logic                      s2_step_y_ff;
   logic [WEIGHT_WIDTH-1:0]   s2_weight_ff [NUM_NEIGHBORS];

   logic [ROW_WIDTH-1:0]      row1;
   logic [ADDR_WIDTH-1:0]     rd_addr [NUM_NEIGHBORS];
   logic                      ram_wr_en;

   // Stage 3: pixels from the store, weights.
   pixel_type                 rd_pixel [NUM_NEIGHBORS];
   logic                      s3_valid_ff;
   logic                      s3_last_ff;
   logic [WEIGHT_WIDTH-1:0]   s3_weight_ff [NUM_NEIGHBORS];
   logic [PROD_WIDTH-1:0]     s4_prod_in [NUM_NEIGHBORS][NUM_CHANNELS];

   // Stage 4: weighted channel terms.
   logic                      s4_valid_ff;
   logic                      s4_last_ff;
   logic [PROD_WIDTH-1:0]     s4_prod_ff [NUM_NEIGHBORS][NUM_CHANNELS];
   logic [ACC_WIDTH-1:0]      acc [NUM_CHANNELS];
   logic [Q88_WIDTH-1:0]      rsp_chan_in [NUM_CHANNELS];

   // Output register.
   logic                      rsp_valid_ff;
   logic                      rsp_last_ff;
   logic [Q88_WIDTH-1:0]      rsp_chan_ff [NUM_CHANNELS];

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= clamp_size(csr_data, MAX_WIDTH);
            CSR_IMAGE_HEIGHT: height_ff <= clamp_size(csr_data, MAX_HEIGHT);
            default: ;
         endcase
      end
   end

   assign width_m1  = width_ff - SIZE_WIDTH'(1);
   assign height_m1 = height_ff - SIZE_WIDTH'(1);

   // ------------------------------------------------------------------------
   // Flow control
   // ------------------------------------------------------------------------
   assign adv5 = !rsp_valid_ff || rsp_ready;
   assign adv4 = !s4_valid_ff || adv5;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         // Write words end at the store and make no result.
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff && (s2_func_ff == FUNC_SAMPLE);
         end
         if (adv4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (adv5) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1
   // ------------------------------------------------------------------------
   always_comb begin
      u_sat    = (req_coord_u > ONE_Q16) ? ONE_Q16 : req_coord_u;
      v_sat    = (req_coord_v > ONE_Q16) ? ONE_Q16 : req_coord_v;
      v_flip   = ONE_Q16 - v_sat;
      s1_xs_in = XS_WIDTH'(u_sat) * XS_WIDTH'(width_m1);
      s1_ys_in = XS_WIDTH'(v_flip) * XS_WIDTH'(height_m1);
      s1_wr_ok_in = (32'(req_pixel_index) < 32'(STORE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_func_ff    <= req_func;
         s1_last_ff    <= req_last_sample;
         s1_wr_ok_ff   <= s1_wr_ok_in;
         s1_wr_addr_ff <= ADDR_WIDTH'(req_pixel_index);
         s1_pixel_ff   <= {req_red_in, req_green_in, req_blue_in};
         s1_xs_ff      <= s1_xs_in;
         s1_ys_ff      <= s1_ys_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2 inputs
   // ------------------------------------------------------------------------
   always_comb begin
      // The integer part stays at or below 510, so nine bits carry it.
      ix0 = s1_xs_ff[FRAC_WIDTH +: SIZE_WIDTH];
      iy0 = s1_ys_ff[FRAC_WIDTH +: SIZE_WIDTH];
      fx  = s1_xs_ff[FRAC_WIDTH-1:0];
      fy  = s1_ys_ff[FRAC_WIDTH-1:0];

      ix0_inc = {1'b0, ix0} + (SIZE_WIDTH+1)'(1);
      iy0_inc = {1'b0, iy0} + (SIZE_WIDTH+1)'(1);
      s2_ix1_in    = (ix0_inc >= {1'b0, width_ff}) ? width_m1 : ix0_inc[SIZE_WIDTH-1:0];
      s2_step_y_in = (iy0_inc < {1'b0, height_ff});
      s2_row0_in   = ROW_WIDTH'(iy0) * ROW_WIDTH'(width_ff);

      x_lo = ONE_Q16 - COORD_WIDTH'(fx);
      x_hi = COORD_WIDTH'(fx);
      y_lo = ONE_Q16 - COORD_WIDTH'(fy);
      y_hi = COORD_WIDTH'(fy);

      // Neighbor order: upper left, lower left, upper right, lower right.
      weight_full[0] = (2*COORD_WIDTH)'(x_lo) * (2*COORD_WIDTH)'(y_lo);
      weight_full[1] = (2*COORD_WIDTH)'(x_lo) * (2*COORD_WIDTH)'(y_hi);
      weight_full[2] = (2*COORD_WIDTH)'(x_hi) * (2*COORD_WIDTH)'(y_lo);
      weight_full[3] = (2*COORD_WIDTH)'(x_hi) * (2*COORD_WIDTH)'(y_hi);
      for (int k = 0; k < NUM_NEIGHBORS; k++) begin
         s2_weight_in[k] = weight_full[k][WEIGHT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_func_ff    <= s1_func_ff;
         s2_last_ff    <= s1_last_ff;
         s2_wr_ok_ff   <= s1_wr_ok_ff;
         s2_wr_addr_ff <= s1_wr_addr_ff;
         s2_pixel_ff   <= s1_pixel_ff;
         s2_ix0_ff     <= ix0;
         s2_ix1_ff     <= s2_ix1_in;
         s2_row0_ff    <= s2_row0_in;
         s2_step_y_ff  <= s2_step_y_in;
         s2_weight_ff  <= s2_weight_in;
      end
   end

   // ------------------------------------------------------------------------
   // Pixel store access. Writes and reads both happen as a word leaves
   // stage 2, so the store sees them in acceptance order.
   // ------------------------------------------------------------------------
   always_comb begin
      row1 = s2_row0_ff + (s2_step_y_ff ? ROW_WIDTH'(width_ff) : '0);
      rd_addr[0] = ADDR_WIDTH'(s2_row0_ff + ROW_WIDTH'(s2_ix0_ff));
      rd_addr[1] = ADDR_WIDTH'(row1 + ROW_WIDTH'(s2_ix0_ff));
      rd_addr[2] = ADDR_WIDTH'(s2_row0_ff + ROW_WIDTH'(s2_ix1_ff));
      rd_addr[3] = ADDR_WIDTH'(row1 + ROW_WIDTH'(s2_ix1_ff));
      ram_wr_en  = s2_valid_ff && (s2_func_ff == FUNC_WRITE) && s2_wr_ok_ff && adv3;
   end

   brs_ram #(
      .DATA_WIDTH (PIXEL_WIDTH),
      .DEPTH      (STORE_DEPTH)
   ) u_ram_upper (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (s2_wr_addr_ff),
      .wr_data   (s2_pixel_ff),
      .rd_en     (adv3),
      .rd_addr_a (rd_addr[0]),
      .rd_addr_b (rd_addr[2]),
      .rd_data_a (rd_pixel[0]),
      .rd_data_b (rd_pixel[2])
   );

   brs_ram #(
      .DATA_WIDTH (PIXEL_WIDTH),
      .DEPTH      (STORE_DEPTH)
   ) u_ram_lower (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (s2_wr_addr_ff),
      .wr_data   (s2_pixel_ff),
      .rd_en     (adv3),
      .rd_addr_a (rd_addr[1]),
      .rd_addr_b (rd_addr[3]),
      .rd_data_a (rd_pixel[1]),
      .rd_data_b (rd_pixel[3])
   );

   // ------------------------------------------------------------------------
   // Stage 3: one multiplier per neighbor and channel
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_last_ff   <= s2_last_ff;
         s3_weight_ff <= s2_weight_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_NEIGHBORS; k++) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            s4_prod_in[k][ch] = PROD_WIDTH'(s3_weight_ff[k]) *
               PROD_WIDTH'(rd_pixel[k][PIXEL_WIDTH - CHAN_WIDTH*(ch+1) +: CHAN_WIDTH]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_last_ff <= s3_last_ff;
         s4_prod_ff <= s4_prod_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: sum, round to nearest and take the Q8.8 bits
   // ------------------------------------------------------------------------
   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         acc[ch] = ACC_WIDTH'(s4_prod_ff[0][ch]) + ACC_WIDTH'(s4_prod_ff[1][ch]) +
                   ACC_WIDTH'(s4_prod_ff[2][ch]) + ACC_WIDTH'(s4_prod_ff[3][ch]) +
                   ROUND_HALF;
         rsp_chan_in[ch] = acc[ch][ROUND_SHIFT +: Q88_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         rsp_last_ff <= s4_last_ff;
         rsp_chan_ff <= rsp_chan_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_chan_ff[0];
   assign rsp_green_out = rsp_chan_ff[1];
   assign rsp_blue_out  = rsp_chan_ff[2];
   assign rsp_last_out  = rsp_last_ff;

endmodule

### rtl/brs_checker.sv
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks of the bilinear RGB image sampler, bound to the top level.
// ----------------------------------------------------------------------------
module brs_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_ready,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [brs_pkg::Q88_WIDTH-1:0]  rsp_red_out,
   input  logic [brs_pkg::Q88_WIDTH-1:0]  rsp_green_out,
   input  logic [brs_pkg::Q88_WIDTH-1:0]  rsp_blue_out,
   input  logic                           rsp_last_out
);

   import brs_pkg::*;

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out) &&
         $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_last_out))
      else $error("result word changed while stalled");

   // A result word leaves only through a handshake.
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result word dropped without handshake");

   // Right after reset, rsp_valid stays low while the pipeline fills.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result word appeared too soon after reset");

   // With the output register free or draining, the input side never stalls.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while the output side was free");

endmodule

bind bilinear_rgb_image_sampler brs_checker u_brs_checker (.*);
